// ===== hdl/hss_pkg.sv =====
// Shared types, constants and helper functions for the humidity sensor read sequencer.
// No dependencies; every other file in hdl/ imports this package.
package hss_pkg;

  // Request codes carried on req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_DONE  = 2'd2;

  // Result kinds carried on out_kind
  localparam logic [1:0] KIND_POWER_ON  = 2'd0;
  localparam logic [1:0] KIND_XFER      = 2'd1;
  localparam logic [1:0] KIND_MEAS      = 2'd2;
  localparam logic [1:0] KIND_POWER_OFF = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_POWERUP_WAIT = 3'd0;
  localparam logic [2:0] CFG_INIT_WAIT    = 3'd1;
  localparam logic [2:0] CFG_MEASURE_WAIT = 3'd2;
  localparam logic [2:0] CFG_BUSY_WAIT    = 3'd3;
  localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd4;

  localparam logic [7:0] RST_POWERUP_WAIT = 8'd49;
  localparam logic [7:0] RST_INIT_WAIT    = 8'd9;
  localparam logic [7:0] RST_MEASURE_WAIT = 8'd89;
  localparam logic [7:0] RST_BUSY_WAIT    = 8'd1;
  localparam logic [2:0] RST_RETRY_LIMIT  = 3'd3;

  // Bus transaction contents
  localparam logic [7:0]  ADDR_READ  = 8'h71;
  localparam logic [7:0]  ADDR_WRITE = 8'h70;
  localparam logic [23:0] CMD_INIT   = 24'hBE0800;
  localparam logic [23:0] CMD_TRIG   = 24'hAC3300;
  localparam logic [3:0]  TOTAL_STAT = 4'd2;
  localparam logic [3:0]  TOTAL_CMD  = 4'd4;
  localparam logic [3:0]  TOTAL_READ = 4'd8;

  // Status byte bits
  localparam int ST_BUSY_BIT = 7;
  localparam int ST_CAL_BIT  = 3;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [2:0] RETRY_MAX   = 3'd7;
  localparam logic [7:0] TIMER_MAX   = 8'hFF;
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_PWR_WAIT   = 5'd1,
    PH_STAT_XFER  = 5'd3,
    PH_STAT_RETRY = 5'd4,
    PH_INIT_XFER  = 5'd6,
    PH_INIT_RETRY = 5'd7,
    PH_INIT_WAIT  = 5'd8,
    PH_TRIG_XFER  = 5'd10,
    PH_TRIG_RETRY = 5'd11,
    PH_MEAS_WAIT  = 5'd12,
    PH_READ_XFER  = 5'd14,
    PH_READ_RETRY = 5'd15
  } phase_t;

  typedef struct packed {
    logic [7:0] powerup_wait;
    logic [7:0] init_wait;
    logic [7:0] measure_wait;
    logic [7:0] busy_wait;
    logic [2:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        xfer_error;
    logic [7:0]  rx_status;
    logic [39:0] rx_data;
    logic [7:0]  rx_crc;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  first_byte;
    logic [23:0] command;
    logic [3:0]  total;
    logic [13:0] humidity;
    logic [14:0] temperature;
    logic        last;
  } res_t;

  // Up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Status byte followed by the five data bytes, first byte in the top bits
  function automatic logic [7:0] crc8_frame(input logic [47:0] bytes);
    logic [7:0] c;
    c = CRC_INIT;
    for (int i = 5; i >= 0; i--) begin
      c = crc8_byte(c, bytes[8*i +: 8]);
    end
    return c;
  endfunction

  function automatic res_t issue_res(input phase_t target);
    res_t r;
    r = '0;
    r.kind = KIND_XFER;
    unique case (target)
      PH_STAT_XFER: begin
        r.first_byte = ADDR_READ;
        r.total      = TOTAL_STAT;
      end
      PH_INIT_XFER: begin
        r.first_byte = ADDR_WRITE;
        r.command    = CMD_INIT;
        r.total      = TOTAL_CMD;
      end
      PH_TRIG_XFER: begin
        r.first_byte = ADDR_WRITE;
        r.command    = CMD_TRIG;
        r.total      = TOTAL_CMD;
      end
      default: begin
        r.first_byte = ADDR_READ;
        r.total      = TOTAL_READ;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/hss_outq.sv =====
// Output queue: four result entries, up to two written and one read per cycle.
// Depends on hss_pkg for res_t, push_t and the queue sizing constants.
module hss_outq (
  input  logic          clk,
  input  logic          rst,
  input  hss_pkg::push_t push,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output hss_pkg::res_t head
);
  import hss_pkg::*;

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];
  // Space for a full two-result transfer, ignoring this cycle's pop
  assign room      = (count <= OQ_CW'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + OQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + OQ_CW'(push.num) - OQ_CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("output queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.num == 2'd0) ||
    ((OQ_CW + 1)'(count) + (OQ_CW + 1)'(push.num) <= (OQ_CW + 1)'(OQ_DEPTH) + (OQ_CW + 1)'(pop)))
    else $error("output queue written while full");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.num == 2'd0) |=> (count == $past(count) - OQ_CW'(1)))
    else $error("output queue count did not drop after read");

endmodule

// ===== hdl/hss_ctrl.sv =====
// Sequencer: phase state, retry and wait timers, CRC check and scaling of one item.
// Depends on hss_pkg for phase_t, cfg_t, item_t, push_t and the CRC helpers.
module hss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  hss_pkg::item_t item,
  input  hss_pkg::cfg_t  cfg,
  output hss_pkg::push_t push
);
  import hss_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  retry_count, retry_count_next;
  logic [7:0]  wait_timer, wait_timer_next;
  logic [19:0] humidity_raw, humidity_raw_next;
  logic [19:0] temperature_raw, temperature_raw_next;

  logic [7:0]  timer_inc;
  logic [2:0]  retry_inc;
  logic        give_up;
  logic        crc_ok;
  logic [33:0] hum_prod;
  logic [34:0] temp_prod;

  logic pwr_on_v, issue_v, meas_v, off_v, do_finish, main_v;
  res_t main_res, off_res;

  assign timer_inc = (wait_timer == TIMER_MAX) ? wait_timer : wait_timer + 8'd1;
  assign retry_inc = (retry_count == RETRY_MAX) ? retry_count : retry_count + 3'd1;
  assign give_up   = (retry_inc >= cfg.retry_limit);
  assign crc_ok    = (crc8_frame({item.rx_status, item.rx_data}) == item.rx_crc);
  assign hum_prod  = 34'(item.rx_data[39:20]) * 34'(HUM_SCALE);
  assign temp_prod = 35'(item.rx_data[19:0]) * 35'(TEMP_SCALE);

  // Next state
  always_comb begin
    phase_next           = phase;
    retry_count_next     = retry_count;
    wait_timer_next      = wait_timer;
    humidity_raw_next    = humidity_raw;
    temperature_raw_next = temperature_raw;
    pwr_on_v  = 1'b0;
    issue_v   = 1'b0;
    meas_v    = 1'b0;
    off_v     = 1'b0;
    do_finish = 1'b0;
    if (go) begin
      unique case (item.req_type)
        REQ_START: begin
          if (phase == PH_IDLE) begin
            wait_timer_next = '0;
            phase_next      = PH_PWR_WAIT;
            pwr_on_v        = 1'b1;
          end
        end
        REQ_TICK: begin
          wait_timer_next = timer_inc;
          unique case (phase)
            PH_PWR_WAIT: begin
              if (timer_inc > cfg.powerup_wait) begin
                retry_count_next = '0;
                phase_next       = PH_STAT_XFER;
                issue_v          = 1'b1;
              end
            end
            PH_STAT_RETRY: begin
              if (timer_inc != '0) begin
                phase_next = PH_STAT_XFER;
                issue_v    = 1'b1;
              end
            end
            PH_INIT_RETRY: begin
              if (timer_inc != '0) begin
                phase_next = PH_INIT_XFER;
                issue_v    = 1'b1;
              end
            end
            PH_INIT_WAIT: begin
              if (timer_inc > cfg.init_wait) begin
                retry_count_next = '0;
                phase_next       = PH_TRIG_XFER;
                issue_v          = 1'b1;
              end
            end
            PH_TRIG_RETRY: begin
              if (timer_inc != '0) begin
                phase_next = PH_TRIG_XFER;
                issue_v    = 1'b1;
              end
            end
            PH_MEAS_WAIT: begin
              if (timer_inc > cfg.measure_wait) begin
                retry_count_next = '0;
                phase_next       = PH_READ_XFER;
                issue_v          = 1'b1;
              end
            end
            PH_READ_RETRY: begin
              if (timer_inc > cfg.busy_wait) begin
                phase_next = PH_READ_XFER;
                issue_v    = 1'b1;
              end
            end
            default: ;
          endcase
        end
        REQ_DONE: begin
          unique case (phase)
            PH_STAT_XFER: begin
              if (item.xfer_error) begin
                retry_count_next = retry_inc;
                if (give_up) begin
                  do_finish = 1'b1;
                end else begin
                  wait_timer_next = '0;
                  phase_next      = PH_STAT_RETRY;
                end
              end else if (item.rx_status[ST_CAL_BIT]) begin
                phase_next = PH_TRIG_XFER;
                issue_v    = 1'b1;
              end else begin
                retry_count_next = '0;
                phase_next       = PH_INIT_XFER;
                issue_v          = 1'b1;
              end
            end
            PH_INIT_XFER: begin
              wait_timer_next = '0;
              if (item.xfer_error) begin
                retry_count_next = retry_inc;
                if (give_up) begin
                  do_finish = 1'b1;
                end else begin
                  phase_next = PH_INIT_RETRY;
                end
              end else begin
                phase_next = PH_INIT_WAIT;
              end
            end
            PH_TRIG_XFER: begin
              wait_timer_next = '0;
              if (item.xfer_error) begin
                retry_count_next = retry_inc;
                if (give_up) begin
                  do_finish = 1'b1;
                end else begin
                  phase_next = PH_TRIG_RETRY;
                end
              end else begin
                phase_next = PH_MEAS_WAIT;
              end
            end
            PH_READ_XFER: begin
              if (item.xfer_error) begin
                retry_count_next = retry_inc;
                if (give_up) begin
                  do_finish = 1'b1;
                end else begin
                  wait_timer_next = '0;
                  phase_next      = PH_READ_RETRY;
                end
              end else if (item.rx_status[ST_BUSY_BIT]) begin
                wait_timer_next = '0;
                phase_next      = PH_READ_RETRY;
              end else begin
                if (crc_ok) begin
                  humidity_raw_next    = item.rx_data[39:20];
                  temperature_raw_next = item.rx_data[19:0];
                  meas_v               = 1'b1;
                end
                do_finish = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      // End of sequence: restart when both raw values are zero, as when nothing was measured yet
      if (do_finish) begin
        if (humidity_raw_next == '0 && temperature_raw_next == '0) begin
          phase_next      = PH_PWR_WAIT;
          wait_timer_next = '0;
        end else begin
          phase_next = PH_IDLE;
          off_v      = 1'b1;
        end
      end
    end
  end

  // Results
  always_comb begin
    main_res = '0;
    off_res  = '0;
    push     = '0;
    if (pwr_on_v) begin
      main_res.kind = KIND_POWER_ON;
    end else if (issue_v) begin
      main_res = issue_res(phase_next);
    end else if (meas_v) begin
      main_res.kind        = KIND_MEAS;
      main_res.humidity    = hum_prod[33:20];
      main_res.temperature = temp_prod[34:20] - TEMP_OFFSET;
    end
    off_res.kind = KIND_POWER_OFF;
    off_res.last = 1'b1;
    main_v = pwr_on_v || issue_v || meas_v;
    if (main_v && off_v) begin
      push.num    = 2'd2;
      push.first  = main_res;
      push.second = off_res;
    end else if (main_v) begin
      push.num        = 2'd1;
      push.first      = main_res;
      push.first.last = 1'b1;
    end else if (off_v) begin
      push.num   = 2'd1;
      push.first = off_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      retry_count     <= '0;
      wait_timer      <= '0;
      humidity_raw    <= '0;
      temperature_raw <= '0;
    end else begin
      phase           <= phase_next;
      retry_count     <= retry_count_next;
      wait_timer      <= wait_timer_next;
      humidity_raw    <= humidity_raw_next;
      temperature_raw <= temperature_raw_next;
    end
  end

endmodule

// ===== hdl/humidity_sensor_read_sequencer.sv =====
// Top level of the humidity sensor read sequencer: input register, config registers,
// sequencer and output queue. Depends on hss_pkg, hss_ctrl and hss_outq.
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  -----------------------------------------
//   in        sink       in_valid / in_stall     req_type xfer_error rx_status rx_data rx_crc
//   out       source     out_valid / out_stall   out_kind xfer_first_byte xfer_command
//                                                xfer_total humidity_x100 temperature_x100
//                                                last_result
//   cfg       sink       cfg_we (no wait)        cfg_index cfg_data
//
// An accepted item is processed while it sits in the input register (CRC check and scaling
// included), once the queue has room for two results, and its 0, 1 or 2 results enter a
// four-entry output queue; one item per cycle is accepted while the queue holds at most two
// results. Each result passes through the input register and the output queue before it is
// shown. Synchronous reset returns the phase to idle, clears timers and raw values, empties the
// queue and loads the register defaults. in_stall rises only while the queue holds more
// than two results, which happens when out_stall keeps the queue from draining.
module humidity_sensor_read_sequencer (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic               xfer_error,
  input  logic [7:0]         rx_status,
  input  logic [39:0]        rx_data,
  input  logic [7:0]         rx_crc,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         xfer_first_byte,
  output logic [23:0]        xfer_command,
  output logic [3:0]         xfer_total,
  output logic [13:0]        humidity_x100,
  output logic signed [14:0] temperature_x100,
  output logic               last_result,
  // configuration port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import hss_pkg::*;

  item_t item;
  logic  in_full;
  logic  room;
  logic  go;
  logic  in_xfer;
  cfg_t  cfg;
  push_t push;
  res_t  head;

  // Process the held item once its results are sure to fit
  assign go       = in_full && room;
  assign in_stall = in_full && !room;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_xfer) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= '{req_type: req_type, xfer_error: xfer_error, rx_status: rx_status,
                rx_data: rx_data, rx_crc: rx_crc};
    end
  end

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.powerup_wait <= RST_POWERUP_WAIT;
      cfg.init_wait    <= RST_INIT_WAIT;
      cfg.measure_wait <= RST_MEASURE_WAIT;
      cfg.busy_wait    <= RST_BUSY_WAIT;
      cfg.retry_limit  <= RST_RETRY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POWERUP_WAIT: cfg.powerup_wait <= cfg_data;
        CFG_INIT_WAIT:    cfg.init_wait    <= cfg_data;
        CFG_MEASURE_WAIT: cfg.measure_wait <= cfg_data;
        CFG_BUSY_WAIT:    cfg.busy_wait    <= cfg_data;
        CFG_RETRY_LIMIT:  cfg.retry_limit  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  hss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (item),
    .cfg  (cfg),
    .push (push)
  );

  hss_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Present the head of the queue
  assign out_kind         = head.kind;
  assign xfer_first_byte  = head.first_byte;
  assign xfer_command     = head.command;
  assign xfer_total       = head.total;
  assign humidity_x100    = head.humidity;
  assign temperature_x100 = $signed(head.temperature);
  assign last_result      = head.last;

endmodule

// ===== verif/humidity_sensor_read_sequencer_tb.sv =====
// Self-checking testbench for humidity_sensor_read_sequencer: random and directed sensor
// sequences, with a cycle-free scoreboard predicting every result. Depends on hss_pkg.
module humidity_sensor_read_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hss_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_OFF    = 6;     // cycles after the last result before a register write
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before the run is abandoned
  localparam int NUM_PHASES  = 9;
  localparam int MAX_REPORTS = 10;

  // Predicts the sequencer: own copy of phase, counters, raw values and registers.
  // Expected results wait in due_results until the output side pops them.
  class sensor_seq_scoreboard;
    cfg_t        cfg;
    phase_t      phase;
    logic [2:0]  retries;
    logic [7:0]  timer;
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
    res_t        due_results[$];
    res_t        batch[$];
    int unsigned items, checked, meas_count, restarts, give_ups, errors;

    function new();
      cfg.powerup_wait = RST_POWERUP_WAIT;
      cfg.init_wait    = RST_INIT_WAIT;
      cfg.measure_wait = RST_MEASURE_WAIT;
      cfg.busy_wait    = RST_BUSY_WAIT;
      cfg.retry_limit  = RST_RETRY_LIMIT;
      phase    = PH_IDLE;
      retries  = '0;
      timer    = '0;
      hum_raw  = '0;
      temp_raw = '0;
    endfunction

    // MSB-first CRC-8 over the status byte and the five data bytes
    function logic [7:0] crc_of(logic [7:0] st, logic [39:0] data);
      logic [47:0] frame;
      logic [7:0]  c;
      frame = {st, data};
      c = CRC_INIT;
      for (int i = 47; i >= 0; i--) begin
        c = (c[7] ^ frame[i]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function void set_cfg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_POWERUP_WAIT: cfg.powerup_wait = val;
        CFG_INIT_WAIT:    cfg.init_wait    = val;
        CFG_MEASURE_WAIT: cfg.measure_wait = val;
        CFG_BUSY_WAIT:    cfg.busy_wait    = val;
        CFG_RETRY_LIMIT:  cfg.retry_limit  = val[2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit is_xfer_phase();
      return phase == PH_STAT_XFER || phase == PH_INIT_XFER ||
             phase == PH_TRIG_XFER || phase == PH_READ_XFER;
    endfunction

    // True for requests that take effect; the block drops the others without any change of state
    function bit takes_effect(item_t it);
      case (it.req_type)
        REQ_START: return phase == PH_IDLE;
        REQ_TICK:  return 1'b1;
        REQ_DONE:  return is_xfer_phase();
        default:   return 1'b0;
      endcase
    endfunction

    function void start_xfer(phase_t target);
      res_t r;
      r = '0;
      r.kind = KIND_XFER;
      phase = target;
      case (target)
        PH_STAT_XFER: begin
          r.first_byte = ADDR_READ;
          r.total      = TOTAL_STAT;
        end
        PH_INIT_XFER: begin
          r.first_byte = ADDR_WRITE;
          r.command    = CMD_INIT;
          r.total      = TOTAL_CMD;
        end
        PH_TRIG_XFER: begin
          r.first_byte = ADDR_WRITE;
          r.command    = CMD_TRIG;
          r.total      = TOTAL_CMD;
        end
        default: begin
          r.first_byte = ADDR_READ;
          r.total      = TOTAL_READ;
        end
      endcase
      batch.push_back(r);
    endfunction

    function bit count_failure();
      if (retries != RETRY_MAX) retries++;
      if (retries >= cfg.retry_limit) give_ups++;
      return retries >= cfg.retry_limit;
    endfunction

    // Power off, or go back to the power-up wait when both raw values are zero
    function void end_sequence();
      res_t r;
      if (hum_raw == '0 && temp_raw == '0) begin
        phase = PH_PWR_WAIT;
        timer = '0;
        restarts++;
      end else begin
        phase = PH_IDLE;
        r = '0;
        r.kind = KIND_POWER_OFF;
        batch.push_back(r);
      end
    endfunction

    function void on_tick();
      if (timer != TIMER_MAX) timer++;
      case (phase)
        PH_PWR_WAIT: if (timer > cfg.powerup_wait) begin
          retries = '0;
          start_xfer(PH_STAT_XFER);
        end
        PH_STAT_RETRY: if (timer != '0) start_xfer(PH_STAT_XFER);
        PH_INIT_RETRY: if (timer != '0) start_xfer(PH_INIT_XFER);
        PH_INIT_WAIT: if (timer > cfg.init_wait) begin
          retries = '0;
          start_xfer(PH_TRIG_XFER);
        end
        PH_TRIG_RETRY: if (timer != '0) start_xfer(PH_TRIG_XFER);
        PH_MEAS_WAIT: if (timer > cfg.measure_wait) begin
          retries = '0;
          start_xfer(PH_READ_XFER);
        end
        PH_READ_RETRY: if (timer > cfg.busy_wait) start_xfer(PH_READ_XFER);
        default: ;
      endcase
    endfunction

    function void on_done(item_t it);
      res_t        r;
      logic [63:0] hprod;
      logic [63:0] tprod;
      logic [14:0] tval;
      case (phase)
        PH_STAT_XFER: begin
          if (it.xfer_error) begin
            if (count_failure()) end_sequence();
            else begin
              timer = '0;
              phase = PH_STAT_RETRY;
            end
          end else if (it.rx_status[ST_CAL_BIT]) begin
            start_xfer(PH_TRIG_XFER);
          end else begin
            retries = '0;
            start_xfer(PH_INIT_XFER);
          end
        end
        PH_INIT_XFER, PH_TRIG_XFER: begin
          timer = '0;
          if (it.xfer_error) begin
            if (count_failure()) end_sequence();
            else phase = (phase == PH_INIT_XFER) ? PH_INIT_RETRY : PH_TRIG_RETRY;
          end else begin
            phase = (phase == PH_INIT_XFER) ? PH_INIT_WAIT : PH_MEAS_WAIT;
          end
        end
        PH_READ_XFER: begin
          if (it.xfer_error) begin
            if (count_failure()) end_sequence();
            else begin
              timer = '0;
              phase = PH_READ_RETRY;
            end
          end else if (it.rx_status[ST_BUSY_BIT]) begin
            timer = '0;
            phase = PH_READ_RETRY;
          end else begin
            // A bad CRC keeps the old raw values and just ends the sequence
            if (crc_of(it.rx_status, it.rx_data) == it.rx_crc) begin
              hum_raw  = it.rx_data[39:20];
              temp_raw = it.rx_data[19:0];
              hprod = 64'(hum_raw) * 64'(HUM_SCALE);
              tprod = 64'(temp_raw) * 64'(TEMP_SCALE);
              tval  = tprod[34:20] - TEMP_OFFSET;
              r = '0;
              r.kind        = KIND_MEAS;
              r.humidity    = hprod[33:20];
              r.temperature = tval;
              batch.push_back(r);
              meas_count++;
            end
            end_sequence();
          end
        end
        default: ;
      endcase
    endfunction

    // Called once per input transfer, in order of acceptance
    function void apply_request(item_t it);
      res_t r;
      batch.delete();
      case (it.req_type)
        REQ_START: if (phase == PH_IDLE) begin
          timer = '0;
          phase = PH_PWR_WAIT;
          r = '0;
          r.kind = KIND_POWER_ON;
          batch.push_back(r);
        end
        REQ_TICK: on_tick();
        REQ_DONE: on_done(it);
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_results.push_back(batch[i]);
      items++;
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result: kind %0d first %h cmd %h total %0d hum %0d temp %0d last %b",
                   $realtime, got.kind, got.first_byte, got.command, got.total,
                   got.humidity, $signed(got.temperature), got.last);
        return;
      end
      exp_r = due_results.pop_front();
      checked++;
      if (got.kind !== exp_r.kind || got.first_byte !== exp_r.first_byte ||
          got.command !== exp_r.command || got.total !== exp_r.total ||
          got.humidity !== exp_r.humidity || got.temperature !== exp_r.temperature ||
          got.last !== exp_r.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch on result %0d", $realtime, checked);
          $display("  expected: kind %0d first %h cmd %h total %0d hum %0d temp %0d last %b",
                   exp_r.kind, exp_r.first_byte, exp_r.command, exp_r.total,
                   exp_r.humidity, $signed(exp_r.temperature), exp_r.last);
          $display("  actual:   kind %0d first %h cmd %h total %0d hum %0d temp %0d last %b",
                   got.kind, got.first_byte, got.command, got.total,
                   got.humidity, $signed(got.temperature), got.last);
        end
      end
    endfunction
  endclass

  // Every input starts at a known value; rst is held from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = '0;
  logic               xfer_error = 1'b0;
  logic [7:0]         rx_status = '0;
  logic [39:0]        rx_data = '0;
  logic [7:0]         rx_crc = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic [7:0]         xfer_first_byte;
  logic [23:0]        xfer_command;
  logic [3:0]         xfer_total;
  logic [13:0]        humidity_x100;
  logic signed [14:0] temperature_x100;
  logic               last_result;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  sensor_seq_scoreboard sb;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  humidity_sensor_read_sequencer uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .xfer_error       (xfer_error),
    .rx_status        (rx_status),
    .rx_data          (rx_data),
    .rx_crc           (rx_crc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .xfer_first_byte  (xfer_first_byte),
    .xfer_command     (xfer_command),
    .xfer_total       (xfer_total),
    .humidity_x100    (humidity_x100),
    .temperature_x100 (temperature_x100),
    .last_result      (last_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure: switch between free flow, light and heavy random stalls and a
  // periodic stall pattern, each kept for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((stall_left % 24) >= 8);
    endcase
  end

  // Check every output transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({out_kind, xfer_first_byte, xfer_command, xfer_total,
                       humidity_x100, temperature_x100, last_result});
  end

  // Abandon the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results still due",
               IDLE_LIMIT, sb.pending());
      $display("humidity_sensor_read_sequencer_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until the transfer; predict its results right there
  task automatic send(input item_t it);
    in_valid <= 1'b1;
    {req_type, xfer_error, rx_status, rx_data, rx_crc} <= it;
    do @(posedge clk); while (in_stall);
    sb.apply_request(it);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_cfg(idx, val);
  endtask

  task automatic write_all(input logic [7:0] pw, input logic [7:0] iw, input logic [7:0] mw,
                           input logic [7:0] bw, input logic [2:0] rl);
    write_cfg(CFG_POWERUP_WAIT, pw);
    write_cfg(CFG_INIT_WAIT, iw);
    write_cfg(CFG_MEASURE_WAIT, mw);
    write_cfg(CFG_BUSY_WAIT, bw);
    write_cfg(CFG_RETRY_LIMIT, {5'd0, rl});
    cfg_we <= 1'b0;
  endtask

  // Wait for every due result, then let any result-free request finish inside the block
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Build a request that plays the sensor's side of the current phase, with some noise
  function automatic item_t make_request(int err_pct);
    item_t it;
    int    roll;
    it.req_type   = 2'($urandom_range(0, 3));
    it.xfer_error = 1'($urandom);
    it.rx_status  = 8'($urandom);
    it.rx_data    = {8'($urandom), 32'($urandom)};
    it.rx_crc     = 8'($urandom);
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 6) return it;
    case (sb.phase)
      PH_IDLE: it.req_type = (roll < 90) ? REQ_START : REQ_TICK;
      PH_STAT_XFER, PH_INIT_XFER, PH_TRIG_XFER, PH_READ_XFER: begin
        it.req_type   = (roll < 92) ? REQ_DONE : REQ_TICK;
        it.xfer_error = ($urandom_range(0, 99) < err_pct);
        if (sb.phase == PH_READ_XFER) begin
          it.rx_status[ST_BUSY_BIT] = ($urandom_range(0, 99) < 25);
          case ($urandom_range(0, 15))
            0: it.rx_data = '0;
            1: it.rx_data = '1;
            2: it.rx_data[39:20] = '0;
            3: it.rx_data[19:0] = '0;
            default: ;
          endcase
          if ($urandom_range(0, 99) < 88) it.rx_crc = sb.crc_of(it.rx_status, it.rx_data);
        end
      end
      default: it.req_type = (roll < 94) ? REQ_TICK : ((roll < 97) ? REQ_START : REQ_DONE);
    endcase
    return it;
  endfunction

  // Send until quota requests have had an effect; bursts of random length, random gaps
  task automatic run_stimulus(input int quota, input int err_pct);
    item_t it;
    int    sent;
    int    burst;
    sent = 0;
    while (sent < quota) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < quota; k++) begin
        it = make_request(err_pct);
        if (sb.takes_effect(it)) sent++;
        send(it);
      end
      if (sent < quota && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  function automatic item_t dir_item(input logic [1:0] req, input logic err,
                                     input logic [7:0] st, input logic [39:0] data,
                                     input bit crc_ok);
    item_t it;
    it.req_type   = req;
    it.xfer_error = err;
    it.rx_status  = st;
    it.rx_data    = data;
    it.rx_crc     = crc_ok ? sb.crc_of(st, data) : ~sb.crc_of(st, data);
    return it;
  endfunction

  // Directed walk with all waits at zero and a retry limit of one
  task automatic run_directed();
    item_t seq_q[$];
    // Ignored requests first: a finish with nothing pending (all-ones fields) and the
    // unused code, then a tick while idle
    seq_q.push_back(dir_item(REQ_DONE, 1'b1, 8'hFF, '1, 1'b1));
    seq_q.push_back(dir_item(REQ_UNUSED, 1'b0, 8'h00, '0, 1'b0));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    // Power on, then a second start while busy
    seq_q.push_back(dir_item(REQ_START, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_START, 1'b1, 8'hFF, '1, 1'b1));
    // Status read fails at once: give up, and with no reading yet, restart silently
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b1, 8'h00, '0, 1'b1));
    // Calibration clear: init command, wait, trigger, wait, read while busy, read again
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h80, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    // All-zero reading with a good CRC: lowest values, then a silent restart
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h1C, '0, 1'b1));
    // Calibration set: straight to trigger, all-ones reading, then power off
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h08, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h7F, '1, 1'b1));
    // New sequence ending in a CRC mismatch: no reading, stored values kept, power off
    seq_q.push_back(dir_item(REQ_START, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h08, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_TICK, 1'b0, 8'h00, '0, 1'b1));
    seq_q.push_back(dir_item(REQ_DONE, 1'b0, 8'h18, 40'h12345_6789A, 1'b0));
    foreach (seq_q[i]) send(seq_q[i]);
    in_valid <= 1'b0;
  endtask

  // Pick one setting per phase: retry-heavy (0), near-saturated (1) and saturated (2, 3, 7)
  // waits, short random waits otherwise
  task automatic configure(input int p, output int quota, output int err_pct);
    logic [7:0] pw, iw, mw, bw;
    logic [2:0] rl;
    pw = 8'($urandom_range(0, 8));
    iw = 8'($urandom_range(0, 8));
    mw = 8'($urandom_range(0, 8));
    bw = 8'($urandom_range(0, 4));
    rl = 3'($urandom_range(1, 7));
    quota   = 200;
    err_pct = 20;
    case (p)
      0: begin
        rl = 3'd7;
        err_pct = 55;
        quota = 250;
      end
      1: begin
        pw = 8'd254;
        quota = 300;
      end
      2: begin
        mw = 8'd255;
        quota = 60;
      end
      3: begin
        iw = 8'd255;
        bw = 8'd255;
        quota = 60;
      end
      7: begin
        pw = 8'd255;
        quota = 30;
      end
      default: ;
    endcase
    write_all(pw, iw, mw, bw, rl);
  endtask

  initial begin
    int quota;
    int err_pct;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Run on the register defaults first
    run_stimulus(300, 15);
    settle();

    write_all(8'd0, 8'd0, 8'd0, 8'd0, 3'd1);
    run_directed();
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(p, quota, err_pct);
      run_stimulus(quota, err_pct);
      settle();
    end

    // Catch any stray result after the queue has run dry
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d register settings, %0d results checked",
             sb.items, NUM_PHASES + 2, sb.checked);
    $display("readings %0d, zero-reading restarts %0d, retry give-ups %0d, mismatches %0d",
             sb.meas_count, sb.restarts, sb.give_ups, sb.errors);
    if (sb.errors == 0) begin
      $display("humidity_sensor_read_sequencer_tb: done, clean");
    end else begin
      $display("humidity_sensor_read_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hss_pkg.sv
hdl/hss_outq.sv
hdl/hss_ctrl.sv
hdl/humidity_sensor_read_sequencer.sv
verif/humidity_sensor_read_sequencer_tb.sv
